[design/asa_pkg.sv]
// Shared constants of the aging slot allocator: operation codes, field widths and tag values.
package asa_pkg;

  localparam int OpcodeWidth   = 2;
  localparam int ObjectIdWidth = 8;
  localparam int ViewerWidth   = 9;
  localparam int SlotOutWidth  = 8;
  localparam int AgeWidth      = 2;

  localparam logic [OpcodeWidth-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OpcodeWidth-1:0] OP_TICK    = 2'd1;
  localparam logic [OpcodeWidth-1:0] OP_REQUEST = 2'd2;

  localparam logic [AgeWidth-1:0] AGE_ZERO = 2'd0;
  localparam logic [AgeWidth-1:0] AGE_FREE = 2'd2;
  localparam logic [AgeWidth-1:0] AGE_MAX  = 2'd3;

  localparam logic [ViewerWidth-1:0] OWNER_NONE = 9'h1FF;

endpackage

[design/asa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module asa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/aging_slot_allocator_unit.sv]
// Top level of the aging slot allocator: sequencer, slot and object tables, result register.
//
// One word is processed at a time, and in_stall_o stays high until its result has been
// moved into the output register. A request that hits reads the object table, then its
// slot, and loads its result; a miss adds a scan of the slot table at one slot per cycle.
// An age tick walks the whole slot table, and a clear writes both tables. A stalled output
// register holds the result back for as long as the stall lasts, and the next word is
// taken in the cycle after the load at the earliest. The slot memory has a single read
// port, visited once per slot. After reset the block runs a clearing pass over both
// tables before it takes its first word.
module aging_slot_allocator_unit #(
  parameter int SLOT_COUNT   = 256,
  parameter int OBJECT_COUNT = 256
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [asa_pkg::OpcodeWidth-1:0]        opcode_i,
  input  logic [asa_pkg::ObjectIdWidth-1:0]      object_id_i,
  input  logic signed [asa_pkg::ViewerWidth-1:0] viewer_id_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [asa_pkg::SlotOutWidth-1:0]       slot_o,
  output logic                                   hit_o,
  output logic                                   no_free_slot_o
);

  localparam int SlotIdxW   = $clog2(SLOT_COUNT);
  localparam int ObjIdxW    = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;
  localparam int SweepDepth = (SLOT_COUNT > OBJECT_COUNT) ? SLOT_COUNT : OBJECT_COUNT;
  localparam int CntW       = $clog2(SweepDepth + 1);

  typedef struct packed {
    logic [asa_pkg::AgeWidth-1:0]    age;
    logic [asa_pkg::ViewerWidth-1:0] owner;
    logic                            obj_vld;
    logic [ObjIdxW-1:0]              obj;
  } slot_entry_t;

  typedef struct packed {
    logic                vld;
    logic [SlotIdxW-1:0] slot;
  } obj_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REQ_SLOT,
    ST_REQ_CHECK,
    ST_SEARCH,
    ST_FORCE_RD,
    ST_FORCE_UNMAP,
    ST_MAP,
    ST_TICK,
    ST_DELIVER
  } state_e;

  localparam slot_entry_t SlotReset = '{
    age:     asa_pkg::AGE_FREE,
    owner:   asa_pkg::OWNER_NONE,
    obj_vld: 1'b0,
    obj:     '0
  };

  state_e                            state_q, state_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic                              pend_q, pend_d;
  logic [SlotIdxW-1:0]               pend_idx_q, pend_idx_d;
  logic                              clear_op_q, clear_op_d;
  logic [ObjIdxW-1:0]                obj_q, obj_d;
  logic [asa_pkg::ViewerWidth-1:0]   viewer_q, viewer_d;
  logic [SlotIdxW-1:0]               old_slot_q, old_slot_d;
  logic [SlotIdxW-1:0]               res_slot_q, res_slot_d;
  logic                              res_hit_q, res_hit_d;
  logic                              res_nfs_q, res_nfs_d;
  logic                              out_valid_q, out_valid_d;
  logic [asa_pkg::SlotOutWidth-1:0]  out_slot_q, out_slot_d;
  logic                              out_hit_q, out_hit_d;
  logic                              out_nfs_q, out_nfs_d;

  logic                slot_we;
  logic [SlotIdxW-1:0] slot_waddr;
  slot_entry_t         slot_wdata;
  logic [SlotIdxW-1:0] slot_raddr;
  slot_entry_t         slot_rdata;
  logic                obj_we;
  logic [ObjIdxW-1:0]  obj_waddr;
  obj_entry_t          obj_wdata;
  logic [ObjIdxW-1:0]  obj_raddr;
  obj_entry_t          obj_rdata;

  logic                         accept;
  logic                         obj_in_range;
  logic                         slot_is_free;
  logic                         slot_owned;
  logic [asa_pkg::AgeWidth-1:0] age_inc;
  logic                         age_expired;
  logic [SlotIdxW-1:0]          cnt_slot;

  asa_ram #(
    .Width($bits(slot_entry_t)),
    .Depth(SLOT_COUNT)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  asa_ram #(
    .Width($bits(obj_entry_t)),
    .Depth(OBJECT_COUNT)
  ) u_obj_ram (
    .clk_i  (clk_i),
    .we_i   (obj_we),
    .waddr_i(obj_waddr),
    .wdata_i(obj_wdata),
    .raddr_i(obj_raddr),
    .rdata_o(obj_rdata)
  );

  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && (state_q == ST_IDLE);
  assign obj_in_range = (32'(object_id_i) < OBJECT_COUNT);
  assign cnt_slot     = cnt_q[SlotIdxW-1:0];

  assign slot_is_free = (slot_rdata.age >= asa_pkg::AGE_FREE) &&
                        (slot_rdata.owner == asa_pkg::OWNER_NONE);
  assign slot_owned   = !slot_rdata.owner[asa_pkg::ViewerWidth-1];
  assign age_inc      = (slot_rdata.age == asa_pkg::AGE_MAX) ? slot_rdata.age :
                        slot_rdata.age + 2'd1;
  assign age_expired  = (age_inc >= asa_pkg::AGE_FREE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    clear_op_d  = clear_op_q;
    obj_d       = obj_q;
    viewer_d    = viewer_q;
    old_slot_d  = old_slot_q;
    res_slot_d  = res_slot_q;
    res_hit_d   = res_hit_q;
    res_nfs_d   = res_nfs_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_slot_d  = out_slot_q;
    out_hit_d   = out_hit_q;
    out_nfs_d   = out_nfs_q;

    slot_we    = 1'b0;
    slot_waddr = cnt_slot;
    slot_wdata = SlotReset;
    slot_raddr = cnt_slot;
    obj_we     = 1'b0;
    obj_waddr  = obj_q;
    obj_wdata  = '0;
    obj_raddr  = ObjIdxW'(object_id_i);

    case (state_q)
      ST_CLEAR: begin
        slot_we   = (cnt_q < CntW'(SLOT_COUNT));
        obj_we    = (cnt_q < CntW'(OBJECT_COUNT));
        obj_waddr = cnt_q[ObjIdxW-1:0];
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CntW'(SweepDepth - 1)) begin
          state_d = clear_op_q ? ST_DELIVER : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_slot_d = '0;
          res_hit_d  = 1'b0;
          res_nfs_d  = 1'b0;
          cnt_d      = '0;
          pend_d     = 1'b0;
          obj_d      = ObjIdxW'(object_id_i);
          viewer_d   = viewer_id_i;
          clear_op_d = 1'b0;
          case (opcode_i)
            asa_pkg::OP_CLEAR: begin
              clear_op_d = 1'b1;
              state_d    = ST_CLEAR;
            end
            asa_pkg::OP_TICK: begin
              state_d = ST_TICK;
            end
            asa_pkg::OP_REQUEST: begin
              state_d = obj_in_range ? ST_REQ_SLOT : ST_DELIVER;
            end
            default: begin
              state_d = ST_DELIVER;
            end
          endcase
        end
      end
      ST_REQ_SLOT: begin
        if (obj_rdata.vld) begin
          slot_raddr = obj_rdata.slot;
          old_slot_d = obj_rdata.slot;
          state_d    = ST_REQ_CHECK;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_REQ_CHECK: begin
        slot_we    = 1'b1;
        slot_waddr = old_slot_q;
        slot_wdata = slot_rdata;
        if (slot_rdata.owner == viewer_q) begin
          slot_wdata.age = asa_pkg::AGE_ZERO;
          res_slot_d     = old_slot_q;
          res_hit_d      = 1'b1;
          state_d        = ST_DELIVER;
        end else begin
          slot_wdata.obj_vld = 1'b0;
          obj_we             = 1'b1;
          state_d            = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (pend_q && slot_is_free) begin
          res_slot_d = pend_idx_q;
          pend_d     = 1'b0;
          state_d    = ST_MAP;
        end else if (cnt_q < CntW'(SLOT_COUNT)) begin
          pend_d     = 1'b1;
          pend_idx_d = cnt_slot;
          cnt_d      = cnt_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_FORCE_RD;
        end
      end
      ST_FORCE_RD: begin
        slot_raddr = '0;
        res_slot_d = '0;
        res_nfs_d  = 1'b1;
        state_d    = ST_FORCE_UNMAP;
      end
      ST_FORCE_UNMAP: begin
        obj_we    = slot_rdata.obj_vld;
        obj_waddr = slot_rdata.obj;
        state_d   = ST_MAP;
      end
      ST_MAP: begin
        slot_we            = 1'b1;
        slot_waddr         = res_slot_q;
        slot_wdata.age     = asa_pkg::AGE_ZERO;
        slot_wdata.owner   = viewer_q;
        slot_wdata.obj_vld = 1'b1;
        slot_wdata.obj     = obj_q;
        obj_we             = 1'b1;
        obj_wdata.vld      = 1'b1;
        obj_wdata.slot     = res_slot_q;
        state_d            = ST_DELIVER;
      end
      ST_TICK: begin
        if (pend_q && slot_owned) begin
          slot_we    = 1'b1;
          slot_waddr = pend_idx_q;
          slot_wdata = slot_rdata;
          if (age_expired) begin
            slot_wdata.age     = asa_pkg::AGE_FREE;
            slot_wdata.owner   = asa_pkg::OWNER_NONE;
            slot_wdata.obj_vld = 1'b0;
            obj_we             = slot_rdata.obj_vld;
            obj_waddr          = slot_rdata.obj;
          end else begin
            slot_wdata.age = age_inc;
          end
        end
        if (cnt_q < CntW'(SLOT_COUNT)) begin
          pend_d     = 1'b1;
          pend_idx_d = cnt_slot;
          cnt_d      = cnt_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_slot_d  = asa_pkg::SlotOutWidth'(res_slot_q);
          out_hit_d   = res_hit_q;
          out_nfs_d   = res_nfs_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      clear_op_q  <= 1'b0;
      obj_q       <= '0;
      viewer_q    <= '0;
      old_slot_q  <= '0;
      res_slot_q  <= '0;
      res_hit_q   <= 1'b0;
      res_nfs_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_slot_q  <= '0;
      out_hit_q   <= 1'b0;
      out_nfs_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      clear_op_q  <= clear_op_d;
      obj_q       <= obj_d;
      viewer_q    <= viewer_d;
      old_slot_q  <= old_slot_d;
      res_slot_q  <= res_slot_d;
      res_hit_q   <= res_hit_d;
      res_nfs_q   <= res_nfs_d;
      out_valid_q <= out_valid_d;
      out_slot_q  <= out_slot_d;
      out_hit_q   <= out_hit_d;
      out_nfs_q   <= out_nfs_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign slot_o         = out_slot_q;
  assign hit_o          = out_hit_q;
  assign no_free_slot_o = out_nfs_q;

endmodule

[design/asa_checker.sv]
// Port-level assertions of the aging slot allocator and the bind that attaches them.
module asa_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic [asa_pkg::SlotOutWidth-1:0]       slot_o,
  input logic                                   hit_o,
  input logic                                   no_free_slot_o
);

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o) && $stable(hit_o) &&
    $stable(no_free_slot_o))
  else $error("stalled result word changed");

  // A reused mapping never coincides with a forced slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && no_free_slot_o))
  else $error("hit and no_free_slot both set");

  // A forced allocation always lands on slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_free_slot_o |-> slot_o == '0)
  else $error("forced allocation not on slot zero");

  // The block is busy in the cycle after it takes a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
  else $error("input not stalled after an accepted word");

endmodule

bind aging_slot_allocator_unit asa_checker u_asa_checker (.*);

[bench/aging_slot_allocator_unit_tb.sv]
// Self-checking testbench of the aging slot allocator with a predicting scoreboard.
module aging_slot_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asa_pkg::*;

  localparam int NUM_SLOTS   = 256;
  localparam int NUM_OBJECTS = 256;
  localparam int NO_MAP      = -1;
  localparam int LONG_HOLD   = 1500;
  localparam int SETTLE      = 300;

  localparam logic [OpcodeWidth-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [SlotOutWidth-1:0] slot;
    logic                    hit;
    logic                    no_free;
  } grant_t;

  class slot_grant_board;
    logic [AgeWidth-1:0]           age_q       [NUM_SLOTS];
    logic signed [ViewerWidth-1:0] owner_tag   [NUM_SLOTS];
    int                            slot_holder [NUM_SLOTS];
    int                            object_home [NUM_OBJECTS];
    grant_t                        grants_due  [$];
    int                            mismatches;

    function new();
      mismatches = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        age_q[i]       = AGE_FREE;
        owner_tag[i]   = OWNER_NONE;
        slot_holder[i] = NO_MAP;
      end
      for (int i = 0; i < NUM_OBJECTS; i++) begin
        object_home[i] = NO_MAP;
      end
    endfunction

    function void unlink(int s, int obj);
      if (obj >= 0 && obj < NUM_OBJECTS) object_home[obj] = NO_MAP;
      if (s >= 0 && s < NUM_SLOTS) slot_holder[s] = NO_MAP;
    endfunction

    function void release_slot(int s);
      if (slot_holder[s] != NO_MAP) unlink(s, slot_holder[s]);
      age_q[s]     = AGE_FREE;
      owner_tag[s] = OWNER_NONE;
    endfunction

    function void age_all();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (owner_tag[i] >= 9'sd0) begin
          if (age_q[i] < AGE_MAX) age_q[i] = age_q[i] + 2'd1;
          if (age_q[i] >= AGE_FREE) release_slot(i);
        end
      end
    endfunction

    function grant_t serve_request(int obj, logic signed [ViewerWidth-1:0] viewer);
      grant_t g;
      int     s;
      g.slot    = '0;
      g.hit     = 1'b0;
      g.no_free = 1'b0;
      if (obj >= NUM_OBJECTS) return g;
      s = object_home[obj];
      if (s >= 0 && s < NUM_SLOTS && owner_tag[s] == viewer) begin
        age_q[s] = AGE_ZERO;
        g.slot   = s[SlotOutWidth-1:0];
        g.hit    = 1'b1;
        return g;
      end
      if (s != NO_MAP) unlink(s, obj);
      s = -1;
      for (int i = 0; i < NUM_SLOTS && s < 0; i++) begin
        if (age_q[i] >= AGE_FREE && owner_tag[i] == OWNER_NONE) s = i;
      end
      if (s < 0) begin
        s         = 0;
        g.no_free = 1'b1;
        if (slot_holder[0] != NO_MAP) unlink(0, slot_holder[0]);
      end
      object_home[obj] = s;
      slot_holder[s]   = obj;
      age_q[s]         = AGE_ZERO;
      owner_tag[s]     = viewer;
      g.slot           = s[SlotOutWidth-1:0];
      return g;
    endfunction

    function void note_word(logic [OpcodeWidth-1:0] op, logic [ObjectIdWidth-1:0] obj,
                            logic signed [ViewerWidth-1:0] viewer);
      grant_t g;
      g.slot    = '0;
      g.hit     = 1'b0;
      g.no_free = 1'b0;
      case (op)
        OP_CLEAR: wipe();
        OP_TICK: age_all();
        OP_REQUEST: g = serve_request(int'(obj), viewer);
        default: ;
      endcase
      grants_due.push_back(g);
    endfunction

    function int pending();
      return grants_due.size();
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %0s", what);
    endtask

    task check_grant(logic [SlotOutWidth-1:0] slot, logic hit, logic no_free);
      grant_t want;
      if (grants_due.size() == 0) begin
        report($sformatf("unexpected result slot=%0d hit=%0b no_free_slot=%0b",
                         slot, hit, no_free));
        return;
      end
      want = grants_due.pop_front();
      if (slot !== want.slot)
        report($sformatf("slot got %0d want %0d", slot, want.slot));
      if (hit !== want.hit)
        report($sformatf("hit got %0b want %0b", hit, want.hit));
      if (no_free !== want.no_free)
        report($sformatf("no_free_slot got %0b want %0b", no_free, want.no_free));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [OpcodeWidth-1:0]         opcode_i;
  logic [ObjectIdWidth-1:0]       object_id_i;
  logic signed [ViewerWidth-1:0]  viewer_id_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [SlotOutWidth-1:0]        slot_o;
  logic                           hit_o;
  logic                           no_free_slot_o;

  slot_grant_board board = new();
  bit              want_long_hold = 1'b0;

  aging_slot_allocator_unit #(
    .SLOT_COUNT  (NUM_SLOTS),
    .OBJECT_COUNT(NUM_OBJECTS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .object_id_i   (object_id_i),
    .viewer_id_i   (viewer_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .slot_o        (slot_o),
    .hit_o         (hit_o),
    .no_free_slot_o(no_free_slot_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_grant(slot_o, hit_o, no_free_slot_o);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [ViewerWidth-1:0] pick_viewer();
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = $urandom_range(0, 3);
    end else if (r < 55) begin
      v = OWNER_NONE;
    end else if (r < 65) begin
      case ($urandom_range(0, 2))
        0: v = 9'h100;
        1: v = 9'h1FE;
        default: v = 9'h0FF;
      endcase
    end else begin
      v = $urandom;
    end
    return v[ViewerWidth-1:0];
  endfunction

  function automatic logic [ObjectIdWidth-1:0] pick_object();
    int unsigned v;
    if ($urandom_range(0, 99) < 60) v = $urandom_range(0, 15);
    else v = $urandom_range(0, 255);
    return v[ObjectIdWidth-1:0];
  endfunction

  task automatic send_word(logic [OpcodeWidth-1:0] op, logic [ObjectIdWidth-1:0] obj,
                           logic signed [ViewerWidth-1:0] vw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    object_id_i <= obj;
    viewer_id_i <= vw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_word(op, obj, vw);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_mixed(int count);
    int                     r;
    logic [OpcodeWidth-1:0] op;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 72) op = OP_REQUEST;
      else if (r < 88) op = OP_TICK;
      else if (r < 91) op = OP_CLEAR;
      else op = OP_UNUSED;
      send_word(op, pick_object(), pick_viewer());
    end
  endtask

  // Enough misses without a tick to use up every slot and force slot 0.
  task automatic run_fill(int count);
    logic [ObjectIdWidth-1:0]      obj;
    logic signed [ViewerWidth-1:0] vw;
    int unsigned                   r;
    send_word(OP_CLEAR, pick_object(), pick_viewer());
    obj = '0;
    vw  = '0;
    for (int k = 0; k < count; k++) begin
      if (k == 0 || $urandom_range(0, 99) >= 15) begin
        r   = $urandom;
        obj = r[ObjectIdWidth-1:0];
        r   = $urandom;
        vw  = r[ViewerWidth-1:0];
      end
      send_word(OP_REQUEST, obj, vw);
    end
  endtask

  initial begin
    int n;
    int m;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (want_long_hold) begin
        want_long_hold = 1'b0;
        n = LONG_HOLD;
      end else begin
        m = $urandom_range(0, 99);
        if (m < 50) n = 0;
        else if (m < 85) n = $urandom_range(1, 3);
        else if (m < 97) n = $urandom_range(4, 12);
        else n = $urandom_range(20, 60);
      end
      if ($urandom_range(0, 99) < 80) m = $urandom_range(1, 4);
      else m = $urandom_range(30, 120);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (m) @(posedge clk_i);
    end
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    opcode_i    <= OP_CLEAR;
    object_id_i <= '0;
    viewer_id_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(OP_CLEAR, 8'd0, 9'sd0);
    send_word(OP_REQUEST, 8'd0, 9'sd0);
    send_word(OP_REQUEST, 8'd0, 9'sd0);
    send_word(OP_REQUEST, 8'd255, 9'sd255);
    send_word(OP_REQUEST, 8'd1, OWNER_NONE);
    send_word(OP_REQUEST, 8'd1, OWNER_NONE);
    send_word(OP_REQUEST, 8'd2, 9'h100);
    send_word(OP_REQUEST, 8'd0, 9'sd1);
    send_word(OP_UNUSED, 8'hAA, 9'h155);
    send_word(OP_TICK, 8'h55, 9'h0AA);
    send_word(OP_REQUEST, 8'd255, 9'sd255);
    send_word(OP_TICK, 8'd0, 9'sd0);
    send_word(OP_REQUEST, 8'd7, 9'sd3);
    send_word(OP_TICK, 8'd0, 9'sd0);
    send_word(OP_TICK, 8'd0, 9'sd0);
    send_word(OP_REQUEST, 8'd2, 9'h100);
    send_word(OP_REQUEST, 8'd1, 9'sd0);
    send_word(OP_REQUEST, 8'd3, 9'h1FE);
    send_word(OP_TICK, 8'd0, 9'sd0);
    send_word(OP_CLEAR, 8'hFF, 9'h1FF);
    send_word(OP_REQUEST, 8'd128, 9'sd128);

    want_long_hold = 1'b1;
    run_mixed(150);
    drain();
    run_fill(330);
    run_mixed(70);

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
